### hw/rtl/rau_pkg.sv
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    localparam logic [31:0] NUM_MAX = 32'd2147483647;
    localparam logic [29:0] DEN_MAX = 30'd1073741823;
    localparam logic [15:0] INT_MAX = 16'd32767;

    localparam logic [2:0] OP_MUL  = 3'd0;
    localparam logic [2:0] OP_DIV  = 3'd1;
    localparam logic [2:0] OP_ADD  = 3'd2;
    localparam logic [2:0] OP_SUB  = 3'd3;
    localparam logic [2:0] OP_PASS = 3'd4;
    localparam logic [2:0] OP_QUOT = 3'd5;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_LOAD     = 4'd0;
    localparam pc_t PC_CHECK    = 4'd1;
    localparam pc_t PC_MUL_N1   = 4'd2;
    localparam pc_t PC_MUL_N2   = 4'd3;
    localparam pc_t PC_MUL_D    = 4'd4;
    localparam pc_t PC_SET_D    = 4'd5;
    localparam pc_t PC_GCD_INIT = 4'd6;
    localparam pc_t PC_GCD_STEP = 4'd7;
    localparam pc_t PC_DIV_N    = 4'd8;
    localparam pc_t PC_DIV_N_RUN = 4'd9;
    localparam pc_t PC_DIV_D    = 4'd10;
    localparam pc_t PC_DIV_D_RUN = 4'd11;
    localparam pc_t PC_SET_DQ   = 4'd12;
    localparam pc_t PC_QUOT     = 4'd13;
    localparam pc_t PC_QUOT_RUN = 4'd14;
    localparam pc_t PC_EMIT     = 4'd15;

    typedef enum logic [3:0] {
        U_NOP,
        U_LOAD,
        U_MUL_N1,
        U_MUL_N2,
        U_MUL_D,
        U_SET_D,
        U_GCD_INIT,
        U_GCD_STEP,
        U_DIV_N,
        U_DIV_D,
        U_DIV_STEP,
        U_SET_DQ,
        U_QUOT,
        U_EMIT
    } uop_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_IS_QUOT,
        C_SKIP_RED,
        C_GCD_BUSY,
        C_DIV_BUSY,
        C_DEN_ZERO,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t cw;
        case (pc)
            PC_LOAD:      cw = '{U_LOAD,     C_NO_INPUT, PC_LOAD};
            PC_CHECK:     cw = '{U_NOP,      C_IS_QUOT,  PC_QUOT};
            PC_MUL_N1:    cw = '{U_MUL_N1,   C_NEVER,    PC_LOAD};
            PC_MUL_N2:    cw = '{U_MUL_N2,   C_NEVER,    PC_LOAD};
            PC_MUL_D:     cw = '{U_MUL_D,    C_NEVER,    PC_LOAD};
            PC_SET_D:     cw = '{U_SET_D,    C_SKIP_RED, PC_EMIT};
            PC_GCD_INIT:  cw = '{U_GCD_INIT, C_NEVER,    PC_LOAD};
            PC_GCD_STEP:  cw = '{U_GCD_STEP, C_GCD_BUSY, PC_GCD_STEP};
            PC_DIV_N:     cw = '{U_DIV_N,    C_NEVER,    PC_LOAD};
            PC_DIV_N_RUN: cw = '{U_DIV_STEP, C_DIV_BUSY, PC_DIV_N_RUN};
            PC_DIV_D:     cw = '{U_DIV_D,    C_NEVER,    PC_LOAD};
            PC_DIV_D_RUN: cw = '{U_DIV_STEP, C_DIV_BUSY, PC_DIV_D_RUN};
            PC_SET_DQ:    cw = '{U_SET_DQ,   C_ALWAYS,   PC_EMIT};
            PC_QUOT:      cw = '{U_QUOT,     C_DEN_ZERO, PC_EMIT};
            PC_QUOT_RUN:  cw = '{U_DIV_STEP, C_DIV_BUSY, PC_QUOT_RUN};
            PC_EMIT:      cw = '{U_EMIT,     C_OUT_FULL, PC_EMIT};
            default:      cw = '{U_NOP,      C_ALWAYS,   PC_LOAD};
        endcase
        return cw;
    endfunction

endpackage

### hw/rtl/rational_arithmetic_unit.sv
// rational arithmetic unit: combines fractions a and b under op, optional gcd reduction
// input channel: in_valid / in_stall with op, reduce, a_num, a_den, b_num, b_den;
//   a transaction is taken when in_valid is high and in_stall is low
// output channel: out_valid / out_stall with res_num, res_den, int_value, zero_den
// control is a 16-step microprogram; in_stall is low only in the load step
// N = 2 * OPERAND_WIDTH; without reduction the steps are load, products and emit;
//   op 5 quotient runs the divider after load, or skips it with a zero denominator;
//   with reduction the products are followed by the binary gcd loop, one shift or
//   subtract on N-bit values per cycle, and by division of numerator and denominator
// undefined op codes run the rational steps and give an all-zero result
// the divider is a restoring divider that gives one quotient bit per cycle
// one transaction is in work at a time; the next can be taken once the result
//   sits in the output register, even while that result waits
// when the receiver stalls, the result holds in the output register and the
//   sequencer waits in its emit step only if a second result is ready
// reset clears the step counter and the output valid; payload is not reset
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               op,
    input  logic                     reduce,
    input  logic [OPERAND_WIDTH-1:0] a_num,
    input  logic [OPERAND_WIDTH-1:0] a_den,
    input  logic [OPERAND_WIDTH-1:0] b_num,
    input  logic [OPERAND_WIDTH-1:0] b_den,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [31:0]       res_num,
    output logic [29:0]              res_den,
    output logic signed [15:0]       int_value,
    output logic                     zero_den
);

    localparam int W  = OPERAND_WIDTH;
    localparam int N  = 2 * W;
    localparam int KW = $clog2(N);
    localparam int CNT_W = $clog2(N + 1);
    localparam int CW = (N > 32) ? N : 32;
    localparam int QW = (W > 16) ? W : 16;

    // sequencer
    pc_t   pc_reg, pc_next;
    ctrl_t cw;
    logic  jump;

    // captured operands
    logic [2:0]   op_reg, op_next;
    logic         red_reg, red_next;
    logic         an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic         an_neg_next, ad_neg_next, bn_neg_next, bd_neg_next;
    logic [W-1:0] an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic [W-1:0] an_mag_next, ad_mag_next, bn_mag_next, bd_mag_next;

    // exact result and product
    logic         n_neg_reg, n_neg_next, d_neg_reg, d_neg_next;
    logic [N-1:0] n_mag_reg, n_mag_next, d_mag_reg, d_mag_next;
    logic         p_neg_reg, p_neg_next;
    logic [N-1:0] p_mag_reg, p_mag_next;

    // gcd
    logic [N-1:0]  u_reg, u_next, v_reg, v_next, g_reg, g_next;
    logic [KW-1:0] k_reg, k_next;
    logic [N-1:0]  u_shifted;

    // divider
    logic [N-1:0]     quo_reg, quo_next, rem_reg, rem_next, dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N:0]       div_sh, div_diff;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic signed [31:0] res_num_reg, res_num_next;
    logic [29:0]       res_den_reg, res_den_next;
    logic signed [15:0] int_value_reg, int_value_next;
    logic              zero_den_reg, zero_den_next;

    // multiplier operands
    logic [W-1:0] mx, my;
    logic         mneg;
    logic [N-1:0] mprod;

    // signed add of accumulated numerator and product
    logic         s_neg;
    logic [N-1:0] s_mag;

    // result formatting
    logic [CW-1:0] nm_ext, dm_ext;
    logic [30:0]   nm_sat;
    logic [29:0]   dm_sat;
    logic          nneg;
    logic [QW-1:0] q_ext;
    logic [14:0]   q_sat;
    logic          qneg;
    logic          out_free;
    logic signed [31:0] f_num;
    logic [29:0]   f_den;
    logic signed [15:0] f_int;
    logic          f_zd;

    assign cw        = ucode(pc_reg);
    assign in_stall  = (pc_reg != PC_LOAD);
    assign out_free  = !(out_valid_reg && out_stall);
    assign u_shifted = u_reg << k_reg;

    always_comb
    begin
        case (cw.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_INPUT: jump = !in_valid;
            C_IS_QUOT:  jump = (op_reg == OP_QUOT);
            C_SKIP_RED: jump = !(red_reg && (n_mag_reg != '0) && (p_mag_reg != '0));
            C_GCD_BUSY: jump = (v_reg != '0);
            C_DIV_BUSY: jump = (cnt_reg != CNT_W'(1));
            C_DEN_ZERO: jump = (ad_mag_reg == '0);
            C_OUT_FULL: jump = !out_free;
            default:    jump = 1'b0;
        endcase
        pc_next = jump ? cw.target : pc_reg + pc_t'(1);
    end

    // multiplier operand select
    always_comb
    begin
        mx   = '0;
        my   = '0;
        mneg = 1'b0;
        case (cw.uop)
            U_MUL_N1:
            begin
                mx = an_mag_reg;
                if (op_reg == OP_MUL)
                begin
                    my   = bn_mag_reg;
                    mneg = an_neg_reg ^ bn_neg_reg;
                end
                else if (op_reg == OP_PASS)
                begin
                    my   = W'(1);
                    mneg = an_neg_reg;
                end
                else
                begin
                    my   = bd_mag_reg;
                    mneg = an_neg_reg ^ bd_neg_reg;
                end
            end
            U_MUL_N2:
            begin
                mx   = bn_mag_reg;
                my   = (op_reg == OP_ADD || op_reg == OP_SUB) ? ad_mag_reg : '0;
                mneg = bn_neg_reg ^ (op_reg == OP_SUB) ^ ad_neg_reg;
            end
            U_MUL_D:
            begin
                mx = ad_mag_reg;
                if (op_reg == OP_DIV)
                begin
                    my   = bn_mag_reg;
                    mneg = ad_neg_reg ^ bn_neg_reg;
                end
                else if (op_reg == OP_PASS)
                begin
                    my   = W'(1);
                    mneg = ad_neg_reg;
                end
                else
                begin
                    my   = bd_mag_reg;
                    mneg = ad_neg_reg ^ bd_neg_reg;
                end
            end
            default:
            begin
                mx   = '0;
                my   = '0;
                mneg = 1'b0;
            end
        endcase
        mprod = N'(mx) * N'(my);
    end

    always_comb
    begin
        if (n_neg_reg == p_neg_reg)
        begin
            s_neg = n_neg_reg;
            s_mag = n_mag_reg + p_mag_reg;
        end
        else if (n_mag_reg >= p_mag_reg)
        begin
            s_neg = n_neg_reg;
            s_mag = n_mag_reg - p_mag_reg;
        end
        else
        begin
            s_neg = p_neg_reg;
            s_mag = p_mag_reg - n_mag_reg;
        end
        if (s_mag == '0)
        begin
            s_neg = 1'b0;
        end
    end

    assign div_sh   = {rem_reg, quo_reg[N-1]};
    assign div_diff = div_sh - {1'b0, dvs_reg};

    // result formatting
    always_comb
    begin
        nm_ext = CW'(n_mag_reg);
        dm_ext = CW'(d_mag_reg);
        nm_sat = (nm_ext > CW'(NUM_MAX)) ? NUM_MAX[30:0] : nm_ext[30:0];
        dm_sat = (dm_ext > CW'(DEN_MAX)) ? DEN_MAX : dm_ext[29:0];
        if (d_mag_reg == '0)
        begin
            nneg = n_neg_reg;
        end
        else
        begin
            nneg = (n_neg_reg != d_neg_reg) && (n_mag_reg != '0);
        end
        q_ext = QW'(quo_reg);
        q_sat = (q_ext > QW'(INT_MAX)) ? INT_MAX[14:0] : q_ext[14:0];
        qneg  = (an_neg_reg != ad_neg_reg) && (q_ext != '0);

        f_num = '0;
        f_den = '0;
        f_int = '0;
        f_zd  = 1'b0;
        if (op_reg == OP_QUOT)
        begin
            f_zd = (ad_mag_reg == '0);
            if (ad_mag_reg != '0)
            begin
                f_int = qneg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
            end
        end
        else if (op_reg inside {[OP_MUL:OP_PASS]})
        begin
            f_zd  = (d_mag_reg == '0);
            f_num = nneg ? -$signed({1'b0, nm_sat}) : $signed({1'b0, nm_sat});
            f_den = dm_sat;
        end
    end

    // datapath
    always_comb
    begin
        op_next     = op_reg;
        red_next    = red_reg;
        an_neg_next = an_neg_reg;
        ad_neg_next = ad_neg_reg;
        bn_neg_next = bn_neg_reg;
        bd_neg_next = bd_neg_reg;
        an_mag_next = an_mag_reg;
        ad_mag_next = ad_mag_reg;
        bn_mag_next = bn_mag_reg;
        bd_mag_next = bd_mag_reg;
        n_neg_next  = n_neg_reg;
        n_mag_next  = n_mag_reg;
        d_neg_next  = d_neg_reg;
        d_mag_next  = d_mag_reg;
        p_neg_next  = p_neg_reg;
        p_mag_next  = p_mag_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        g_next      = g_reg;
        k_next      = k_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        cnt_next    = cnt_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        int_value_next = int_value_reg;
        zero_den_next  = zero_den_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (cw.uop)
            U_LOAD:
            begin
                if (in_valid)
                begin
                    op_next     = op;
                    red_next    = reduce;
                    an_neg_next = a_num[W-1];
                    ad_neg_next = a_den[W-1];
                    bn_neg_next = b_num[W-1];
                    bd_neg_next = b_den[W-1];
                    an_mag_next = a_num[W-1] ? -a_num : a_num;
                    ad_mag_next = a_den[W-1] ? -a_den : a_den;
                    bn_mag_next = b_num[W-1] ? -b_num : b_num;
                    bd_mag_next = b_den[W-1] ? -b_den : b_den;
                end
            end
            U_MUL_N1:
            begin
                p_mag_next = mprod;
                p_neg_next = mneg && (mprod != '0);
            end
            U_MUL_N2:
            begin
                n_mag_next = p_mag_reg;
                n_neg_next = p_neg_reg;
                p_mag_next = mprod;
                p_neg_next = mneg && (mprod != '0);
            end
            U_MUL_D:
            begin
                n_mag_next = s_mag;
                n_neg_next = s_neg;
                p_mag_next = mprod;
                p_neg_next = mneg && (mprod != '0);
            end
            U_SET_D:
            begin
                d_mag_next = p_mag_reg;
                d_neg_next = p_neg_reg;
            end
            U_GCD_INIT:
            begin
                u_next = n_mag_reg;
                v_next = d_mag_reg;
                k_next = '0;
            end
            U_GCD_STEP:
            begin
                if (v_reg != '0)
                begin
                    if (!u_reg[0] && !v_reg[0])
                    begin
                        u_next = u_reg >> 1;
                        v_next = v_reg >> 1;
                        k_next = k_reg + KW'(1);
                    end
                    else if (!u_reg[0])
                    begin
                        u_next = u_reg >> 1;
                    end
                    else if (!v_reg[0])
                    begin
                        v_next = v_reg >> 1;
                    end
                    else if (u_reg > v_reg)
                    begin
                        u_next = v_reg;
                        v_next = u_reg - v_reg;
                    end
                    else
                    begin
                        v_next = v_reg - u_reg;
                    end
                end
            end
            U_DIV_N:
            begin
                g_next   = u_shifted;
                quo_next = n_mag_reg;
                dvs_next = u_shifted;
                rem_next = '0;
                cnt_next = CNT_W'(N);
            end
            U_DIV_D:
            begin
                n_mag_next = quo_reg;
                quo_next   = d_mag_reg;
                dvs_next   = g_reg;
                rem_next   = '0;
                cnt_next   = CNT_W'(N);
            end
            U_DIV_STEP:
            begin
                if (!div_diff[N])
                begin
                    rem_next = div_diff[N-1:0];
                    quo_next = {quo_reg[N-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_sh[N-1:0];
                    quo_next = {quo_reg[N-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
            U_SET_DQ:
            begin
                d_mag_next = quo_reg;
            end
            U_QUOT:
            begin
                quo_next = N'(an_mag_reg);
                dvs_next = N'(ad_mag_reg);
                rem_next = '0;
                cnt_next = CNT_W'(N);
            end
            U_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    res_num_next   = f_num;
                    res_den_next   = f_den;
                    int_value_next = f_int;
                    zero_den_next  = f_zd;
                end
            end
            default:
            begin
                op_next = op_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        red_reg       <= red_next;
        an_neg_reg    <= an_neg_next;
        ad_neg_reg    <= ad_neg_next;
        bn_neg_reg    <= bn_neg_next;
        bd_neg_reg    <= bd_neg_next;
        an_mag_reg    <= an_mag_next;
        ad_mag_reg    <= ad_mag_next;
        bn_mag_reg    <= bn_mag_next;
        bd_mag_reg    <= bd_mag_next;
        n_neg_reg     <= n_neg_next;
        n_mag_reg     <= n_mag_next;
        d_neg_reg     <= d_neg_next;
        d_mag_reg     <= d_mag_next;
        p_neg_reg     <= p_neg_next;
        p_mag_reg     <= p_mag_next;
        u_reg         <= u_next;
        v_reg         <= v_next;
        g_reg         <= g_next;
        k_reg         <= k_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        cnt_reg       <= cnt_next;
        res_num_reg   <= res_num_next;
        res_den_reg   <= res_den_next;
        int_value_reg <= int_value_next;
        zero_den_reg  <= zero_den_next;
    end

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign int_value = int_value_reg;
    assign zero_den  = zero_den_reg;

endmodule

### hw/rtl/rau_checker.sv
module rau_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic signed [31:0] res_num,
    input logic [29:0]       res_den,
    input logic signed [15:0] int_value,
    input logic              zero_den
);

    // busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(res_den)
        && $stable(int_value) && $stable(zero_den))
        else $error("stalled result changed");

    a_zero_den_clears_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_den |-> res_den == 30'd0)
        else $error("zero denominator flag with nonzero denominator");

    // integer and rational fields never both in use
    a_int_excludes_frac: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && int_value != 16'sd0 |-> res_num == 32'sd0 && res_den == 30'd0)
        else $error("integer result mixed with fraction");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
